// ----- design/positional_array_table_macros.svh -----
// assertion macros for the positional array table rtl, used by the sequencer
`ifndef POSITIONAL_ARRAY_TABLE_MACROS_SVH
`define POSITIONAL_ARRAY_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PAT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pat_pkg.sv -----
// types, codes and sizes shared by the positional array table modules
package pat_pkg;

	localparam int DEPTH  = 64;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int FUNC_W = 3;
	localparam int POS_W  = 7;
	localparam int WORD_W = 32;
	localparam int STAT_W = 3;
	localparam int IDX_W  = 6;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DISPLAY = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	// one result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  index;
		logic              last;
	} res_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_DAT  = 5'b00100,
		ST_PUT  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

// ----- design/pat_ram.sv -----
// generic single-write, single-read memory with registered read data
module pat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/pat_ctrl.sv -----
// sequencer: decodes each operation and walks the element memory
`include "positional_array_table_macros.svh"

module pat_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	// operation beat
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pat_pkg::FUNC_W-1:0]  in_func,
	input  logic [pat_pkg::POS_W-1:0]   in_pos,
	input  logic [pat_pkg::WORD_W-1:0]  in_val,
	// result path
	input  logic                        res_space,
	output logic                        res_valid,
	output pat_pkg::res_t               res,
	// element memory
	output logic                        wr_en,
	output logic [pat_pkg::AW-1:0]      wr_addr,
	output logic [pat_pkg::WORD_W-1:0]  wr_data,
	output logic                        rd_en,
	output logic [pat_pkg::AW-1:0]      rd_addr,
	input  logic [pat_pkg::WORD_W-1:0]  rd_data
);

	localparam int AW    = pat_pkg::AW;
	localparam int CW    = pat_pkg::CW;
	localparam int POS_W = pat_pkg::POS_W;
	localparam int IDX_W = pat_pkg::IDX_W;

	pat_pkg::state_t                state_q;
	logic [pat_pkg::FUNC_W-1:0]     op_q;
	logic [POS_W-1:0]               pos_q;
	logic [pat_pkg::WORD_W-1:0]     val_q;
	logic [AW-1:0]                  addr_q;
	logic [CW-1:0]                  cnt_q;
	logic [pat_pkg::STAT_W-1:0]     pend_status_q;
	logic [pat_pkg::WORD_W-1:0]     pend_word_q;
	logic [IDX_W-1:0]               pend_idx_q;

	logic          in_fire;
	logic [CW-1:0] cnt_dec;
	logic [AW-1:0] cnt_m1;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] addr_up;
	logic [AW-1:0] addr_dn;
	logic          last_addr;
	logic          hit;

	// address arithmetic
	assign in_ready  = (state_q == pat_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cnt_dec   = cnt_q - CW'(1);
	assign cnt_m1    = cnt_dec[AW-1:0];
	assign pos_a     = pos_q[AW-1:0];
	assign addr_up   = addr_q + AW'(1);
	assign addr_dn   = addr_q - AW'(1);
	assign last_addr = (addr_q == cnt_m1);
	assign hit       = (rd_data == val_q);

	// memory read issue
	assign rd_en   = (state_q == pat_pkg::ST_RD);
	assign rd_addr = addr_q;

	// memory write: shift moves and the final insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_up;
		wr_data = rd_data;
		if (state_q == pat_pkg::ST_DAT) begin
			case (op_q)
				pat_pkg::FN_INSERT: begin
					wr_en   = 1'b1;
					wr_addr = addr_up;
				end
				pat_pkg::FN_DELETE: begin
					wr_en   = (addr_q != pos_a);
					wr_addr = addr_dn;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end else if (state_q == pat_pkg::ST_PUT) begin
			wr_en   = 1'b1;
			wr_addr = pos_a;
			wr_data = val_q;
		end
	end

	// result beats: display words straight from memory, else the pending result
	always_comb begin
		res_valid  = 1'b0;
		res.status = pend_status_q;
		res.word   = pend_word_q;
		res.index  = pend_idx_q;
		res.last   = 1'b1;
		if (state_q == pat_pkg::ST_EMIT) begin
			res_valid = res_space;
		end else if (state_q == pat_pkg::ST_DAT && op_q == pat_pkg::FN_DISPLAY) begin
			res_valid  = res_space;
			res.status = pat_pkg::ST_OK;
			res.word   = rd_data;
			res.index  = IDX_W'(addr_q);
			res.last   = last_addr;
		end
	end

	// control state and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pat_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				pat_pkg::ST_IDLE: begin
					if (in_fire) begin
						unique case (in_func) inside
							pat_pkg::FN_CLEAR: begin
								cnt_q   <= '0;
								state_q <= pat_pkg::ST_EMIT;
							end
							pat_pkg::FN_DISPLAY, pat_pkg::FN_SEARCH: begin
								state_q <= (cnt_q == '0) ? pat_pkg::ST_EMIT : pat_pkg::ST_RD;
							end
							pat_pkg::FN_INSERT: begin
								if (cnt_q >= CW'(pat_pkg::DEPTH) || in_pos > POS_W'(cnt_q)) begin
									state_q <= pat_pkg::ST_EMIT;
								end else if (in_pos == POS_W'(cnt_q)) begin
									state_q <= pat_pkg::ST_PUT;
								end else begin
									state_q <= pat_pkg::ST_RD;
								end
							end
							pat_pkg::FN_DELETE: begin
								if (cnt_q == '0 || in_pos >= POS_W'(cnt_q)) begin
									state_q <= pat_pkg::ST_EMIT;
								end else begin
									state_q <= pat_pkg::ST_RD;
								end
							end
							default: begin
								state_q <= pat_pkg::ST_IDLE;
							end
						endcase
					end
				end
				pat_pkg::ST_RD: begin
					state_q <= pat_pkg::ST_DAT;
				end
				pat_pkg::ST_DAT: begin
					case (op_q)
						pat_pkg::FN_INSERT: begin
							state_q <= (addr_q == pos_a) ? pat_pkg::ST_PUT : pat_pkg::ST_RD;
						end
						pat_pkg::FN_DELETE: begin
							if (last_addr) begin
								cnt_q   <= cnt_dec;
								state_q <= pat_pkg::ST_EMIT;
							end else begin
								state_q <= pat_pkg::ST_RD;
							end
						end
						pat_pkg::FN_SEARCH: begin
							state_q <= (hit || last_addr) ? pat_pkg::ST_EMIT : pat_pkg::ST_RD;
						end
						pat_pkg::FN_DISPLAY: begin
							if (res_space) begin
								state_q <= last_addr ? pat_pkg::ST_IDLE : pat_pkg::ST_RD;
							end
						end
						default: begin
							state_q <= pat_pkg::ST_IDLE;
						end
					endcase
				end
				pat_pkg::ST_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= pat_pkg::ST_EMIT;
				end
				pat_pkg::ST_EMIT: begin
					if (res_space) begin
						state_q <= pat_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pat_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// operation operands, walk address and pending result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q          <= in_func;
			pos_q         <= in_pos;
			val_q         <= in_val;
			pend_word_q   <= '0;
			pend_idx_q    <= '0;
			pend_status_q <= pat_pkg::ST_OK;
			addr_q        <= '0;
			case (in_func) inside
				pat_pkg::FN_DISPLAY, pat_pkg::FN_SEARCH: begin
					if (cnt_q == '0) begin
						pend_status_q <= pat_pkg::ST_EMPTY;
					end
				end
				pat_pkg::FN_INSERT: begin
					addr_q <= cnt_m1;
					if (cnt_q >= CW'(pat_pkg::DEPTH)) begin
						pend_status_q <= pat_pkg::ST_FULL;
					end else if (in_pos > POS_W'(cnt_q)) begin
						pend_status_q <= pat_pkg::ST_BADPOS;
					end
				end
				pat_pkg::FN_DELETE: begin
					addr_q <= in_pos[AW-1:0];
					if (cnt_q == '0) begin
						pend_status_q <= pat_pkg::ST_EMPTY;
					end else if (in_pos >= POS_W'(cnt_q)) begin
						pend_status_q <= pat_pkg::ST_BADPOS;
					end
				end
				default: begin
					pend_status_q <= pat_pkg::ST_OK;
				end
			endcase
		end else if (state_q == pat_pkg::ST_DAT) begin
			case (op_q)
				pat_pkg::FN_INSERT: begin
					addr_q <= addr_dn;
				end
				pat_pkg::FN_DELETE: begin
					if (addr_q == pos_a) begin
						pend_word_q <= rd_data;
					end
					addr_q <= addr_up;
				end
				pat_pkg::FN_SEARCH: begin
					if (hit) begin
						pend_idx_q <= IDX_W'(addr_q);
					end else if (last_addr) begin
						pend_status_q <= pat_pkg::ST_NOTFOUND;
					end
					addr_q <= addr_up;
				end
				pat_pkg::FN_DISPLAY: begin
					if (res_space) begin
						addr_q <= addr_up;
					end
				end
				default: begin
					addr_q <= addr_q;
				end
			endcase
		end
	end

	// checks
	`PAT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(pat_pkg::DEPTH), "count above depth")
	`PAT_ASSERT_NXT(a_clear_empties, in_fire && in_func == pat_pkg::FN_CLEAR, cnt_q == '0, "clear left elements")
	`PAT_ASSERT_IMP(a_wr_in_range, wr_en, POS_W'(wr_addr) <= POS_W'(cnt_q), "write beyond held range")
	`PAT_ASSERT_NXT(a_rd_then_dat, rd_en, state_q == pat_pkg::ST_DAT, "read data not consumed")

endmodule

// ----- design/pat_out.sv -----
// output register that holds one result beat for the master side
module pat_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  pat_pkg::res_t res,
	output logic          res_space,
	output logic          out_valid,
	input  logic          out_ready,
	output pat_pkg::res_t out_res
);

	logic vld_q;

	// room when empty or when the held beat leaves now
	assign res_space = !vld_q || out_ready;
	assign out_valid = vld_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_space) begin
			vld_q <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_space && res_valid) begin
			out_res <= res;
		end
	end

endmodule

// ----- design/positional_array_table.sv -----
// top level of the positional array table: ordered store with clear, display, insert, delete and search
//
//  channel  | direction | payload
//  s_axis   | in        | func, position, value (one operation per beat)
//  m_axis   | out       | status, word, index, tlast = last result of the operation
//
//  each held element costs a memory read, then its use or write-back (one read port,
//  registered read data). display walks all elements; insert shifts the tail up,
//  delete shifts it down, search stops at a hit. error, clear and empty cases go
//  straight to the result. a full output register stalls display walks and results.
//  reset clears the count and control only; the memory is not swept.
module positional_array_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // func[2:0], position[9:3], value[41:10], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // status[2:0], word[34:3], index[40:35], zero
	output logic        m_axis_tlast
);

	logic                        res_valid;
	logic                        res_space;
	pat_pkg::res_t               res;
	pat_pkg::res_t               out_res;
	logic                        wr_en;
	logic [pat_pkg::AW-1:0]      wr_addr;
	logic [pat_pkg::WORD_W-1:0]  wr_data;
	logic                        rd_en;
	logic [pat_pkg::AW-1:0]      rd_addr;
	logic [pat_pkg::WORD_W-1:0]  rd_data;

	// operation sequencer
	pat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tdata[2:0]),
		.in_pos    (s_axis_tdata[9:3]),
		.in_val    (s_axis_tdata[41:10]),
		.res_space (res_space),
		.res_valid (res_valid),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// element memory
	pat_ram #(
		.WIDTH (pat_pkg::WORD_W),
		.DEPTH (pat_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register
	pat_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_space (res_space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack the result beat
	assign m_axis_tdata = {7'd0, out_res.index, out_res.word, out_res.status};
	assign m_axis_tlast = out_res.last;

endmodule
